>>> sv/ddo_pkg.sv
// ddo_pkg: shared types, constants and tables for the odometry block.
// No dependencies.
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
    localparam logic [25:0] DEG360 = 26'd23592960;
    localparam logic signed [27:0] DEG360_S = 28'sd23592960;
    localparam logic signed [27:0] DEG180_S = 28'sd11796480;
    localparam logic signed [27:0] DEG90_S = 28'sd5898240;
    localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam int QDEPTH = 2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_WHEEL_BASE = 1'b1;

    typedef struct packed {
        logic signed [31:0] travel;
        logic signed [25:0] heading;
    } t_cmd;

    function automatic logic signed [27:0] atan_q16(input logic [4:0] i);
        logic signed [27:0] r;
        case (i)
            5'd0: r = 28'sd2949120;  5'd1: r = 28'sd1740967;
            5'd2: r = 28'sd919879;   5'd3: r = 28'sd466945;
            5'd4: r = 28'sd234379;   5'd5: r = 28'sd117266;
            5'd6: r = 28'sd58666;    5'd7: r = 28'sd29335;
            5'd8: r = 28'sd14668;    5'd9: r = 28'sd7334;
            5'd10: r = 28'sd3667;    5'd11: r = 28'sd1833;
            5'd12: r = 28'sd917;     5'd13: r = 28'sd458;
            5'd14: r = 28'sd229;     5'd15: r = 28'sd115;
            5'd16: r = 28'sd57;      5'd17: r = 28'sd29;
            5'd18: r = 28'sd14;      5'd19: r = 28'sd7;
            5'd20: r = 28'sd4;       5'd21: r = 28'sd2;
            5'd22: r = 28'sd1;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/ddo_front.sv
// ddo_front: accepts samples, works out travelled total and heading.
// Mode 0 uses a 54-bit product and a bit-serial divider. Uses ddo_pkg.
module ddo_front import ddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [30:0]        i_wheel_base,
    input  logic signed [31:0] i_left_dist,
    input  logic signed [31:0] i_right_dist,
    input  logic signed [31:0] i_center_dist,
    input  logic [24:0]        i_gyro_angle,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_full
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_MUL = 5'b00010, S_DIV = 5'b00100,
        S_MOD = 5'b01000, S_OUT = 5'b10000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [53:0] r_num;
    logic [30:0] r_den;
    logic [30:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [32:0] r_mag;
    logic signed [31:0] r_dist;
    logic signed [25:0] r_head;
    logic [25:0] r_q;

    logic signed [33:0] w_l, w_r, w_diff, w_sum;
    logic [31:0] w_rem_sh;
    logic [31:0] w_rem_sub;
    logic        w_qbit;
    logic [26:0] w_qmod;

    assign w_l = -{{2{i_left_dist[31]}}, i_left_dist};
    assign w_r = {{2{i_right_dist[31]}}, i_right_dist};
    assign w_diff = w_l - w_r;
    assign w_sum = w_l + w_r;
    assign w_rem_sh = {r_rem, r_num[53]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_qbit = (w_rem_sh >= {1'b0, r_den});
    // quotient kept modulo 360 degrees as its bits come out
    assign w_qmod = {r_q, w_qbit} - {1'b0, DEG360};

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd_valid = (r_state == S_OUT);
    assign o_cmd.travel = r_dist;
    assign o_cmd.heading = r_head;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = i_mode ? S_OUT : S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_cnt == 6'd53) n_state = S_MOD;
            S_MOD:  n_state = S_OUT;
            S_OUT:  if (!i_cmd_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                if (i_mode) begin
                    r_dist <= i_center_dist;
                    r_head <= 26'(DEG360) - 26'({1'b0, i_gyro_angle});
                end else begin
                    r_dist <= 32'(w_sum >>> 1);
                    r_neg <= w_diff[33];
                    r_mag <= w_diff[33] ? 33'(-w_diff) : 33'(w_diff);
                    r_den <= (i_wheel_base == 31'd0) ? 31'd1 : i_wheel_base;
                end
            end
            S_MUL: begin
                r_num <= 54'(r_mag) * 54'(RAD2DEG_Q16);
                r_rem <= '0;
                r_cnt <= '0;
                r_q <= '0;
            end
            S_DIV: begin
                r_cnt <= r_cnt + 6'd1;
                r_num <= {r_num[52:0], w_qbit};
                r_rem <= w_qbit ? w_rem_sub[30:0] : w_rem_sh[30:0];
                r_q <= w_qmod[26] ? {r_q[24:0], w_qbit} : w_qmod[25:0];
            end
            S_MOD: ;
            default: ;
        endcase
        if (r_state == S_MOD) begin
            r_head <= r_neg ? -$signed(r_q) : $signed(r_q);
        end
    end
endmodule

>>> sv/ddo_queue.sv
// ddo_queue: short FIFO of commands between front and back.
// Uses ddo_pkg.
module ddo_queue import ddo_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_cmd o_data
);
    t_cmd r_mem [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'(QDEPTH));
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

>>> sv/ddo_back.sv
// ddo_back: CORDIC direction, position update and output register.
// Uses ddo_pkg.
module ddo_back import ddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [31:0] o_travelled,
    output logic signed [25:0] o_heading_deg
);
    typedef enum logic [5:0] {
        B_IDLE = 6'b000001, B_FOLD = 6'b000010, B_ROT = 6'b000100,
        B_MUL = 6'b001000, B_ACC = 6'b010000, B_OUT = 6'b100000
    } t_bstate;

    t_bstate r_state, n_state;
    logic signed [27:0] r_a;
    logic signed [33:0] r_x, r_y;
    logic [STEP_W-1:0]  r_i;
    logic               r_flip;
    logic signed [32:0] r_dl;
    logic signed [15:0] r_dx, r_dy;
    logic signed [49:0] r_px, r_py;
    logic signed [31:0] r_accx, r_accy, r_prev;
    logic signed [31:0] r_trav;
    logic signed [25:0] r_head;

    logic signed [27:0] w_a0, w_a1;
    logic signed [33:0] w_xs, w_ys, w_xr, w_yr;
    logic signed [15:0] w_cx, w_cy;
    logic signed [50:0] w_sx, w_sy;

    assign o_cmd_pop = (r_state == B_IDLE) && i_cmd_valid;
    assign o_valid = (r_state == B_OUT);
    assign o_pos_x = r_accx;
    assign o_pos_y = r_accy;
    assign o_dir_x = r_dx;
    assign o_dir_y = r_dy;
    assign o_travelled = r_trav;
    assign o_heading_deg = r_head;

    always_comb begin
        w_a0 = 28'(r_head);
        if (w_a0 > DEG180_S) w_a0 = w_a0 - DEG360_S;
        if (w_a0 < -DEG180_S) w_a0 = w_a0 + DEG360_S;
        w_a1 = w_a0;
        if (w_a0 > DEG90_S) w_a1 = w_a0 - DEG180_S;
        else if (w_a0 < -DEG90_S) w_a1 = w_a0 + DEG180_S;
    end

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;

    function automatic logic signed [15:0] rnd14(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) return 16'sd16384;
        if (t < -34'sd16384) return -16'sd16384;
        return 16'(t);
    endfunction

    assign w_xr = r_x;
    assign w_yr = r_y;
    assign w_cx = r_flip ? -rnd14(w_xr) : rnd14(w_xr);
    assign w_cy = r_flip ? -rnd14(w_yr) : rnd14(w_yr);

    function automatic logic signed [31:0] sat(input logic signed [50:0] v);
        if (v > 51'sd2147483647) return 32'sh7fffffff;
        if (v < -51'sd2147483648) return 32'sh80000000;
        return 32'(v);
    endfunction

    assign w_sx = 51'(r_accx) + 51'((r_px + 50'sd8192) >>> 14);
    assign w_sy = 51'(r_accy) + 51'((r_py + 50'sd8192) >>> 14);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (i_cmd_valid) n_state = B_FOLD;
            B_FOLD: n_state = B_ROT;
            B_ROT:  if (r_i == STEP_W'(CORDIC_STEPS - 1)) n_state = B_MUL;
            B_MUL:  n_state = B_ACC;
            B_ACC:  n_state = B_OUT;
            B_OUT:  if (!i_stall) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_accx <= '0;
            r_accy <= '0;
            r_prev <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_IDLE && i_cmd_valid) begin
                r_head <= i_cmd.heading;
                r_trav <= i_cmd.travel;
                r_dl <= 33'(i_cmd.travel) - 33'(r_prev);
                r_prev <= i_cmd.travel;
            end
            if (r_state == B_ACC) begin
                r_accx <= sat(w_sx);
                r_accy <= sat(w_sy);
            end
        end
        case (r_state)
            B_FOLD: begin
                r_a <= w_a1;
                r_flip <= (w_a0 > DEG90_S) || (w_a0 < -DEG90_S);
                r_x <= CORDIC_GAIN_Q30;
                r_y <= '0;
                r_i <= '0;
            end
            B_ROT: begin
                r_i <= r_i + STEP_W'(1);
                if (r_a >= 0) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_a <= r_a - atan_q16(5'(r_i));
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_a <= r_a + atan_q16(5'(r_i));
                end
            end
            B_MUL: begin
                r_dx <= w_cx;
                r_dy <= w_cy;
                r_px <= 50'(r_dl * w_cx);
                r_py <= 50'(r_dl * w_cy);
            end
            default: ;
        endcase
    end
endmodule

>>> sv/differential_drive_odometry_top.sv
// differential_drive_odometry_top: odometry block top level.
// Instantiates ddo_front, ddo_queue, ddo_back; uses ddo_pkg.
//
// Usage: one sample item enters on i_valid/o_stall, one result item leaves
// on o_valid/i_stall. Registers (mode, wheel_base) are written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Mode 0 forms the
// product, runs the 54-step serial divider and applies the sign; mode 1 takes
// the centre distance and 360 degrees minus the gyro angle. The back end then
// runs CORDIC_STEPS iterations of one shared rotator. The front divider limits
// the item rate in mode 0, the back end in mode 1; the front stalls while busy.
// A two-entry queue separates the front from the back.
// Reset: synchronous, active low; clears position, previous total,
// mode to 0 and wheel_base to 65536.
// When the receiver stalls, the result holds; the queue fills and then the
// front stalls the sender.
module differential_drive_odometry_top import ddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_left_dist,
    input  logic signed [31:0] i_right_dist,
    input  logic signed [31:0] i_center_dist,
    input  logic [24:0]        i_gyro_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [31:0] o_travelled,
    output logic signed [25:0] o_heading_deg
);
    logic        r_mode;
    logic [30:0] r_wheel_base;
    logic        w_cmd_valid, w_full, w_pop, w_nonempty;
    t_cmd        w_cmd, w_qdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_wheel_base <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:       r_mode <= i_cfg_data[0];
                CFG_WHEEL_BASE: r_wheel_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ddo_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_mode(r_mode), .i_wheel_base(r_wheel_base),
        .i_left_dist, .i_right_dist, .i_center_dist, .i_gyro_angle,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_full(w_full)
    );

    ddo_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(w_cmd_valid && !w_full), .i_data(w_cmd), .o_full(w_full),
        .i_pop(w_pop), .o_nonempty(w_nonempty), .o_data(w_qdata)
    );

    ddo_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_nonempty), .i_cmd(w_qdata), .o_cmd_pop(w_pop),
        .o_valid, .i_stall,
        .o_pos_x, .o_pos_y, .o_dir_x, .o_dir_y, .o_travelled, .o_heading_deg
    );

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384 &&
                     o_dir_y <= 16'sd16384 && o_dir_y >= -16'sd16384))
        else $error("direction out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_nonempty)
        else $error("pop from empty queue");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pos_x)))
        else $error("result changed under stall");
endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for differential_drive_odometry_top.
// Predicts each result item with an in-bench odometry model; uses ddo_pkg.
module tb_top import ddo_pkg::*;;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [31:0] travelled;
        logic signed [25:0] heading_deg;
    } t_odo;

    typedef struct {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic signed [31:0] center;
        logic [24:0] gyro;
        bit chk;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
    } t_row;

    localparam int WATCHDOG = 200000;
    localparam int TAIL = 200;

    logic i_clk, i_rst_n, i_cfg_we, i_cfg_index;
    logic [30:0] i_cfg_data;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [31:0] i_left_dist, i_right_dist, i_center_dist;
    logic [24:0] i_gyro_angle;
    logic signed [31:0] o_pos_x, o_pos_y, o_travelled;
    logic signed [15:0] o_dir_x, o_dir_y;
    logic signed [25:0] o_heading_deg;

    differential_drive_odometry_top u_dut (.*);

    logic m_mode;
    logic [30:0] m_wbase;
    logic signed [31:0] m_prev, m_x, m_y;
    t_odo pending_odo[$];
    t_row fixed_rows[$];
    int errors = 0, n_in = 0, n_out = 0, idle_cnt = 0;
    int send_idle = 0, recv_idle = 0;
    bit long_hold = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip14(longint v);
        return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
    endfunction

    function automatic longint sat_32(longint v);
        return v > 64'sd2147483647 ? 64'sd2147483647 :
               (v < -64'sd2147483648 ? -64'sd2147483648 : v);
    endfunction

    task automatic rotate_heading(input longint ang, output longint cx, output longint cy);
        longint a, x, y, t;
        bit flip;
        a = ang; x = CORDIC_GAIN_Q30; y = 0; flip = 0;
        if (a > DEG180_S) a -= DEG360_S;
        if (a < -DEG180_S) a += DEG360_S;
        if (a > DEG90_S) begin a -= DEG180_S; flip = 1; end
        else if (a < -DEG90_S) begin a += DEG180_S; flip = 1; end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (a >= 0) begin
                t = x - sra(y, i); y = y + sra(x, i); x = t;
                a -= longint'(atan_q16(5'(i)));
            end else begin
                t = x + sra(y, i); y = y - sra(x, i); x = t;
                a += longint'(atan_q16(5'(i)));
            end
        end
        cx = clip14(sra(x + 32768, 16));
        cy = clip14(sra(y + 32768, 16));
        if (flip) begin cx = -cx; cy = -cy; end
    endtask

    task automatic predict_odo(input t_row r);
        longint lv, rv, diff, trav, hd, inc, cx, cy;
        longint unsigned mag, wb, q;
        t_odo e;
        if (m_mode == 1'b0) begin
            lv = -longint'(r.left); rv = longint'(r.right);
            diff = lv - rv;
            mag = diff < 0 ? -diff : diff;
            wb = (m_wbase == 0) ? 64'd1 : 64'(m_wbase);
            q = (mag * 64'd3754936) / wb;
            q = q % 64'd23592960;
            hd = diff < 0 ? -longint'(q) : longint'(q);
            trav = sra(lv + rv, 1);
        end else begin
            hd = 64'sd23592960 - longint'(r.gyro);
            trav = longint'(r.center);
        end
        inc = trav - longint'(m_prev);
        m_prev = trav[31:0];
        rotate_heading(hd, cx, cy);
        m_x = 32'(sat_32(longint'(m_x) + sra(inc * cx + 8192, 14)));
        m_y = 32'(sat_32(longint'(m_y) + sra(inc * cy + 8192, 14)));
        e.pos_x = m_x; e.pos_y = m_y; e.dir_x = cx[15:0]; e.dir_y = cy[15:0];
        e.travelled = m_prev; e.heading_deg = hd[25:0];
        pending_odo.push_back(e);
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_MODE) m_mode = val[0]; else m_wbase = val;
    endtask

    task automatic drain_idle();
        @(negedge i_clk);
        i_valid <= 0;
        while (pending_odo.size() != 0) @(negedge i_clk);
        repeat (TAIL) @(negedge i_clk);
    endtask

    // offers one item, predicts it when it is accepted and checks a marked table row
    task automatic send_item(input t_row r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_left_dist <= r.left; i_right_dist <= r.right;
        i_center_dist <= r.center; i_gyro_angle <= r.gyro;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_odo(r);
        n_in++;
        if (r.chk && (pending_odo[$].pos_x !== r.px || pending_odo[$].pos_y !== r.py ||
                      pending_odo[$].dir_x !== r.dx || pending_odo[$].dir_y !== r.dy)) begin
            $display("%0t table row mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     $time, r.px, r.py, r.dx, r.dy, pending_odo[$].pos_x,
                     pending_odo[$].pos_y, pending_odo[$].dir_x, pending_odo[$].dir_y);
            errors++;
        end
    endtask

    function automatic t_row rand_row(input int kind);
        t_row r;
        r.chk = 0; r.px = 0; r.py = 0; r.dx = 0; r.dy = 0;
        r.left = $urandom; r.right = $urandom; r.center = $urandom;
        r.gyro = 25'($urandom_range(23592960));
        if (kind < 7) begin
            // smooth trajectory around the previous total
            r.right = m_prev + $signed($urandom_range(4000)) - 2000;
            r.left = -(m_prev + $signed($urandom_range(4000)) - 2000);
            r.center = m_prev + $signed($urandom_range(20000)) - 10000;
        end
        if (kind == 8) r.gyro = 25'($urandom);
        return r;
    endfunction

    function automatic t_row mk(input logic signed [31:0] l, input logic signed [31:0] rr,
                                input logic signed [31:0] c, input logic [24:0] g);
        t_row r;
        r.left = l; r.right = rr; r.center = c; r.gyro = g; r.chk = 0;
        r.px = 0; r.py = 0; r.dx = 0; r.dy = 0;
        return r;
    endfunction

    // receiver and checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_out++;
            if (pending_odo.size() == 0) begin
                $display("%0t unexpected item: got x=%0d y=%0d", $time, o_pos_x, o_pos_y);
                errors++;
            end else begin
                t_odo e;
                e = pending_odo.pop_front();
                if (e.pos_x !== o_pos_x || e.pos_y !== o_pos_y || e.dir_x !== o_dir_x ||
                    e.dir_y !== o_dir_y || e.travelled !== o_travelled ||
                    e.heading_deg !== o_heading_deg) begin
                    $display("%0t mismatch exp x=%0d y=%0d dx=%0d dy=%0d t=%0d h=%0d", $time,
                             e.pos_x, e.pos_y, e.dir_x, e.dir_y, e.travelled, e.heading_deg);
                    $display("%0t          got x=%0d y=%0d dx=%0d dy=%0d t=%0d h=%0d", $time,
                             o_pos_x, o_pos_y, o_dir_x, o_dir_y, o_travelled, o_heading_deg);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (long_hold) i_stall <= 1;
        else i_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || long_hold) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_row r;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0; i_valid = 0;
        i_left_dist = 0; i_right_dist = 0; i_center_dist = 0; i_gyro_angle = 0;
        m_mode = 0; m_wbase = 65536; m_prev = 0; m_x = 0; m_y = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // zero sample after reset: straight ahead, no motion
        r = mk(0, 0, 0, 0); r.chk = 1; r.dx = 16384; r.dy = 0;
        fixed_rows.push_back(r);
        fixed_rows.push_back(mk(-256, 256, 0, 0));
        fixed_rows.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 0, 0));
        fixed_rows.push_back(mk(32'sh80000000, 32'sh7fffffff, 0, 0));
        fixed_rows.push_back(mk(32'sh7fffffff, 32'sh80000000, 0, 0));
        fixed_rows.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 25'h1ffffff));
        fixed_rows.push_back(mk(-1000, -1000, 5, 5));
        fixed_rows.push_back(mk(0, 0, 0, 0));
        foreach (fixed_rows[i]) send_item(fixed_rows[i]);
        drain_idle();
        write_reg(CFG_WHEEL_BASE, 31'd0);
        send_item(mk(-5000, 300, 0, 0));
        send_item(mk(32'sh80000000, 32'sh80000000, 0, 0));
        drain_idle();
        write_reg(CFG_WHEEL_BASE, 31'h7fffffff);
        send_item(mk(32'sh80000000, 32'sh7fffffff, 0, 0));
        drain_idle();
        write_reg(CFG_MODE, 31'd1);
        send_item(mk(0, 0, 1000, 25'd0));
        send_item(mk(0, 0, 2000, 25'd5898240));
        send_item(mk(0, 0, 3000, 25'd11796480));
        send_item(mk(0, 0, 4000, 25'd17694720));
        send_item(mk(0, 0, 32'sh7fffffff, 25'd23592960));
        send_item(mk(0, 0, 32'sh80000000, 25'd23592961));
        send_item(mk(0, 0, 32'sh7fffffff, 25'h1ffffff));
        drain_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0; recv_idle = 0; end
                1: begin send_idle = 76; recv_idle = 0; end
                2: begin send_idle = 0; recv_idle = 76; end
                default: begin send_idle = 26; recv_idle = 26; end
            endcase
            write_reg(CFG_MODE, 31'(ph[0]));
            case (ph)
                2: write_reg(CFG_WHEEL_BASE, 31'd1);
                5: write_reg(CFG_WHEEL_BASE, 31'h7fffffff);
                default: write_reg(CFG_WHEEL_BASE, 31'($urandom_range(32'h7fffffff, 1)));
            endcase
            if (ph == 4) fork
                begin
                    long_hold = 1;
                    repeat (3000) @(negedge i_clk);
                    long_hold = 0;
                end
            join_none
            for (int k = 0; k < 180; k++) send_item(rand_row($urandom_range(9)));
            drain_idle();
        end

        $display("Summary: %0d items sent, %0d results checked, both modes and extremes.",
                 n_in, n_out);
        if (errors == 0 && pending_odo.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
sv/ddo_pkg.sv
sv/ddo_front.sv
sv/ddo_queue.sv
sv/ddo_back.sv
sv/differential_drive_odometry_top.sv
tb/sv/tb_top.sv
